>>> sv/fut_pkg.sv
// Shared types and constants for the font unicode table mapper.
// Beat structs, front-to-back command, back FSM states. No dependencies.
package fut_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int NSLOT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CODE_W    = 16;
  localparam int GLYPH_W   = 13;
  localparam int MAP_DEPTH = 1 << CODE_W;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] BYTE_END  = 8'hFF;
  localparam logic [7:0] BYTE_SKIP = 8'hFE;
  localparam logic [7:0] ALIAS_HI  = 8'hF0;
  localparam logic [GLYPH_W-1:0] ALIAS_LIMIT = GLYPH_W'(256);

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  typedef enum logic {
    REG_GLYPH_COUNT  = 1'b0,
    REG_DEFAULT_FONT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] table_byte;
  } in_t;

  typedef struct packed {
    logic              slot_allocated;
    logic [11:0]       source_glyph;
    logic [SLOT_W-1:0] slot_value;
    logic              map_written;
    logic [15:0]       map_code;
    logic              alias_written;
    logic [15:0]       alias_code;
    logic              font_done;
    logic              overflow;
  } out_t;

  typedef enum logic [2:0] {
    CMD_BEGIN,  // new font: drop current slot, all-zero result but font_done
    CMD_DONE,   // byte past the last list
    CMD_NONE,   // report current slot only
    CMD_END,    // report, then drop current slot
    CMD_BIND    // bind a completed code point
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CODE_W-1:0]   code;
    logic [GLYPH_W-1:0]  glyph;
    logic                font_done;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_CHECK,
    B_ALIAS,
    B_EMIT
  } back_state_t;

endpackage

>>> sv/fut_front.sv
// Front end: takes input beats, decodes UTF-8, tracks glyph lists.
// Emits one command per beat into the queue. Uses fut_pkg.
module fut_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fut_pkg::in_t                in_data,
  input  logic [fut_pkg::GLYPH_W-1:0] glyph_count,
  input  logic                        stall,
  output logic                        push_valid,
  input  logic                        push_ready,
  output fut_pkg::cmd_t               push_data
);
  import fut_pkg::*;

  logic [GLYPH_W-1:0] glyph_counter, glyph_counter_next;
  logic [7:0]         lead_byte, lead_byte_next;
  logic [7:0]         first_continuation, first_continuation_next;
  logic [1:0]         pending_count, pending_count_next;
  logic               accept;
  logic [7:0]         b;

  assign in_ready   = push_ready && !stall;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && !stall;
  assign b          = in_data.table_byte;

  always_comb begin
    glyph_counter_next      = glyph_counter;
    lead_byte_next          = lead_byte;
    first_continuation_next = first_continuation;
    pending_count_next      = pending_count;
    push_data.kind          = CMD_NONE;
    push_data.code          = '0;
    push_data.glyph         = glyph_counter;
    push_data.font_done     = 1'b0;
    if (in_data.req_type == REQ_BEGIN) begin
      glyph_counter_next  = '0;
      pending_count_next  = 2'd0;
      push_data.kind      = CMD_BEGIN;
      push_data.glyph     = '0;
      push_data.font_done = (glyph_count == '0);
    end else if (glyph_counter >= glyph_count) begin
      push_data.kind      = CMD_DONE;
      push_data.font_done = 1'b1;
    end else begin
      if (pending_count != 2'd0) begin
        if (lead_byte[7:5] == 3'b110) begin
          pending_count_next = 2'd0;
          push_data.kind     = CMD_BIND;
          push_data.code     = {5'd0, lead_byte[4:0], b[5:0]};
        end else if (pending_count == 2'd2) begin
          first_continuation_next = b;
          pending_count_next      = 2'd1;
        end else begin
          pending_count_next = 2'd0;
          push_data.kind     = CMD_BIND;
          push_data.code     = {lead_byte[3:0], first_continuation[5:0], b[5:0]};
        end
      end else if (b == BYTE_END) begin
        push_data.kind     = CMD_END;
        glyph_counter_next = glyph_counter + 1'b1;
      end else if (b == BYTE_SKIP) begin
        push_data.kind = CMD_NONE;
      end else if (!b[7]) begin
        push_data.kind = CMD_BIND;
        push_data.code = {8'd0, b};
      end else if (b[7:5] == 3'b110) begin
        lead_byte_next     = b;
        pending_count_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        lead_byte_next     = b;
        pending_count_next = 2'd2;
      end else begin
        // stray continuation or 4-byte lead: code 0
        push_data.kind = CMD_BIND;
      end
      push_data.font_done = (glyph_counter_next >= glyph_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_counter      <= '0;
      lead_byte          <= '0;
      first_continuation <= '0;
      pending_count      <= 2'd0;
    end else if (accept) begin
      glyph_counter      <= glyph_counter_next;
      lead_byte          <= lead_byte_next;
      first_continuation <= first_continuation_next;
      pending_count      <= pending_count_next;
    end
  end

endmodule

>>> sv/fut_queue.sv
// Short command queue between front and back ends.
// Register-based, QDEPTH entries of cmd_t. Uses fut_pkg.
module fut_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  fut_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fut_pkg::cmd_t pop_data
);
  import fut_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/fut_back.sv
// Back end: code map memory, slot allocation, alias writes, output register.
// Clears the map after reset. Uses fut_pkg.
module fut_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          default_font,
  output logic          clearing,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  fut_pkg::cmd_t pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fut_pkg::out_t out_data
);
  import fut_pkg::*;

  logic [SLOT_W-1:0] code_map [MAP_DEPTH];
  logic [SLOT_W-1:0] rd_data;
  logic [CODE_W-1:0] clr_addr;

  back_state_t       state, state_next;
  cmd_t              cmd;
  out_t              res, res_next, emit_data, idle_data, check_data;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic [NSLOT_W-1:0] next_slot, next_slot_next;

  logic              out_free, emit, res_load, cmd_load;
  logic              mem_we;
  logic [CODE_W-1:0] mem_waddr;
  logic [SLOT_W-1:0] mem_wdata;

  logic              need_map, grab, exhausted, map_wr, alias_wr;
  logic [SLOT_W-1:0] slot_new;
  logic [CODE_W-1:0] alias_addr;

  assign out_free   = !out_valid || out_ready;
  assign clearing   = (state == B_CLEAR);

  // decision once the map entry has been read
  assign need_map   = (cmd.code != '0) && (rd_data == '0);
  assign grab       = need_map && (current_slot == '0);
  assign exhausted  = (next_slot >= NSLOT_W'(MAX_SLOTS));
  assign slot_new   = (grab && !exhausted) ? next_slot[SLOT_W-1:0] : current_slot;
  assign map_wr     = need_map && (slot_new != '0);
  assign alias_wr   = default_font && (slot_new != '0) && (cmd.glyph < ALIAS_LIMIT);
  assign alias_addr = {ALIAS_HI, cmd.glyph[7:0]};

  always_comb begin
    check_data                = '0;
    check_data.slot_allocated = grab && !exhausted;
    check_data.source_glyph   = cmd.glyph[11:0];
    check_data.slot_value     = slot_new;
    check_data.map_written    = map_wr;
    check_data.map_code       = cmd.code;
    check_data.alias_written  = alias_wr;
    check_data.alias_code     = alias_wr ? alias_addr : '0;
    check_data.font_done      = cmd.font_done;
    check_data.overflow       = grab && exhausted;
  end

  always_comb begin
    idle_data           = '0;
    idle_data.font_done = pop_data.font_done;
    case (pop_data.kind)
      CMD_BEGIN: ;
      CMD_DONE:  idle_data.source_glyph = pop_data.glyph[11:0];
      CMD_NONE,
      CMD_END: begin
        idle_data.source_glyph = pop_data.glyph[11:0];
        idle_data.slot_value   = current_slot;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_addr == '1) state_next = B_IDLE;
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_data.kind == CMD_BIND) state_next = B_CHECK;
          else if (!out_free)            state_next = B_EMIT;
        end
      end
      B_CHECK: begin
        if (alias_wr)      state_next = B_ALIAS;
        else if (out_free) state_next = B_IDLE;
        else               state_next = B_EMIT;
      end
      B_ALIAS: state_next = out_free ? B_IDLE : B_EMIT;
      B_EMIT:  if (out_free) state_next = B_IDLE;
      default: state_next = B_CLEAR;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    pop_ready         = 1'b0;
    cmd_load          = 1'b0;
    emit              = 1'b0;
    emit_data         = res;
    res_load          = 1'b0;
    res_next          = check_data;
    mem_we            = 1'b0;
    mem_waddr         = clr_addr;
    mem_wdata         = '0;
    current_slot_next = current_slot;
    next_slot_next    = next_slot;
    case (state)
      B_CLEAR: mem_we = 1'b1;
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_data.kind == CMD_BIND) begin
            cmd_load = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_data = idle_data;
            res_load  = 1'b1;
            res_next  = idle_data;
            if (pop_data.kind == CMD_BEGIN || pop_data.kind == CMD_END)
              current_slot_next = '0;
          end
        end
      end
      B_CHECK: begin
        res_load          = 1'b1;
        res_next          = check_data;
        emit              = !alias_wr;
        emit_data         = check_data;
        current_slot_next = slot_new;
        if (grab && !exhausted) next_slot_next = next_slot + 1'b1;
        mem_we    = map_wr;
        mem_waddr = cmd.code;
        mem_wdata = slot_new;
      end
      B_ALIAS: begin
        emit      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = alias_addr;
        mem_wdata = current_slot;
      end
      B_EMIT: emit = 1'b1;
      default: ;
    endcase
  end

  // map memory: one write port, registered read at the queue head code
  always_ff @(posedge clk) begin
    if (mem_we) code_map[mem_waddr] <= mem_wdata;
    rd_data <= code_map[pop_data.code];
  end

  always_ff @(posedge clk) begin
    if (cmd_load) cmd <= pop_data;
    if (res_load) res <= res_next;
    if (emit && out_free) out_data <= emit_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CLEAR;
      clr_addr     <= '0;
      current_slot <= '0;
      next_slot    <= NSLOT_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      current_slot <= current_slot_next;
      next_slot    <= next_slot_next;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (emit && out_free)  out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
    end
  end

  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result beat during map clearing");

  a_map_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.map_written || out_data.alias_written)
      |-> out_data.slot_value != '0)
    else $error("map write with slot zero");

  a_alloc_vs_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.slot_allocated && out_data.overflow))
    else $error("allocation and overflow in one beat");

  a_next_slot_range: assert property (@(posedge clk) disable iff (rst)
    (next_slot != '0) && (next_slot <= NSLOT_W'(MAX_SLOTS)))
    else $error("next_slot out of range");

  a_slot_bump: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHECK) && grab && !exhausted |=> next_slot == $past(next_slot) + 1'b1)
    else $error("allocation did not advance next_slot");

endmodule

>>> sv/font_unicode_table_mapper.sv
// A beat that binds nothing goes from the queue to the output register from B_IDLE;
// one that binds a code passes B_IDLE and B_CHECK, and B_ALIAS when an alias entry
// is also written. The back end takes a new queue entry only in B_IDLE, so bytes
// that bind codes hold the flow; the front takes a byte per cycle while the queue
// has room and the map is not clearing. Reset (rst, sync) clears the 65536-entry
// map with in_ready low; config writes are taken throughout.
module font_unicode_table_mapper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fut_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fut_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fut_pkg::GLYPH_W-1:0] cfg_data
);
  import fut_pkg::*;

  logic [GLYPH_W-1:0] glyph_count;
  logic               default_font;
  logic               clearing;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  cmd_t               push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count  <= GLYPH_W'(256);
      default_font <= 1'b1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_GLYPH_COUNT:  glyph_count  <= cfg_data;
        REG_DEFAULT_FONT: default_font <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fut_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .glyph_count(glyph_count),
    .stall      (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fut_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fut_back u_back (
    .clk         (clk),
    .rst         (rst),
    .default_font(default_font),
    .clearing    (clearing),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> dv/testbench.sv
// Self-checking bench for font_unicode_table_mapper: UTF-8 table bytes in, slot reports out.
// Holds its own model of the code map and slot allocator. Depends on fut_pkg and the RTL.
module testbench;
  import fut_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [GLYPH_W-1:0] cfg_data;

  font_unicode_table_mapper DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [SLOT_W-1:0] slot_of_code [MAP_DEPTH];
  logic [10:0] next_free;
  logic [12:0] glyph_idx;
  logic [SLOT_W-1:0] glyph_slot;
  logic [7:0] lead;
  logic [7:0] cont1;
  logic [1:0] pending;
  logic [12:0] cfg_glyphs;
  logic cfg_default;

  out_t slot_reports_due [$];
  out_t oldest;
  int mismatches = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic idle_on = 1'b1;

  function automatic void bind_code(input logic [15:0] code, inout out_t r);
    logic [15:0] alias_at;
    r.map_code = code;
    if (code != 16'h0 && slot_of_code[code] == '0) begin
      if (glyph_slot == '0) begin
        if (next_free >= MAX_SLOTS) r.overflow = 1'b1;
        else begin
          glyph_slot = next_free[SLOT_W-1:0];
          next_free = next_free + 11'd1;
          r.slot_allocated = 1'b1;
        end
      end
      if (glyph_slot != '0) begin
        slot_of_code[code] = glyph_slot;
        r.map_written = 1'b1;
      end
    end
    // alias rewritten on every completed code, even code 0 or a known one
    if (cfg_default && glyph_slot != '0 && glyph_idx < ALIAS_LIMIT) begin
      alias_at = {ALIAS_HI, glyph_idx[7:0]};
      slot_of_code[alias_at] = glyph_slot;
      r.alias_written = 1'b1;
      r.alias_code = alias_at;
    end
  endfunction

  function automatic out_t predict_table_byte(input in_t beat);
    out_t r;
    logic [7:0] b;
    r = '0;
    b = beat.table_byte;
    if (beat.req_type == REQ_BEGIN) begin
      glyph_idx = '0;
      glyph_slot = '0;
      pending = '0;
      r.font_done = (cfg_glyphs == '0);
      return r;
    end
    r.source_glyph = glyph_idx[11:0];
    if (glyph_idx >= cfg_glyphs) begin
      r.font_done = 1'b1;
      return r;
    end
    if (pending != 2'd0) begin
      // inside a sequence every byte is data, 0xFF and 0xFE too
      if (lead[7:5] == 3'b110) begin
        pending = 2'd0;
        bind_code({5'b0, lead[4:0], b[5:0]}, r);
      end else if (pending == 2'd2) begin
        cont1 = b;
        pending = 2'd1;
      end else begin
        pending = 2'd0;
        bind_code({lead[3:0], cont1[5:0], b[5:0]}, r);
      end
      r.slot_value = glyph_slot;
    end else if (b == BYTE_END) begin
      r.slot_value = glyph_slot;
      glyph_slot = '0;
      glyph_idx = glyph_idx + 13'd1;
    end else if (b == BYTE_SKIP) begin
      r.slot_value = glyph_slot;
    end else if (!b[7]) begin
      bind_code({8'h00, b}, r);
      r.slot_value = glyph_slot;
    end else if (b[7:5] == 3'b110) begin
      lead = b;
      pending = 2'd1;
      r.slot_value = glyph_slot;
    end else if (b[7:4] == 4'b1110) begin
      lead = b;
      pending = 2'd2;
      r.slot_value = glyph_slot;
    end else begin
      // stray continuation or 4-byte lead decodes to code 0
      bind_code(16'h0000, r);
      r.slot_value = glyph_slot;
    end
    r.font_done = (glyph_idx >= cfg_glyphs);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic send_beat(input logic req, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, table_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    slot_reports_due.push_back(predict_table_byte(in_data));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(REQ_BYTE, b);
  endtask

  task automatic start_font();
    send_beat(REQ_BEGIN, 8'($urandom));
  endtask

  // continuation top bits are not checked by the block
  function automatic logic [1:0] cont_marker();
    return ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b10;
  endfunction

  task automatic send_code(input logic [15:0] code);
    if (code < 16'h80) begin
      send_byte(code[7:0]);
    end else if (code < 16'h800) begin
      send_byte({3'b110, code[10:6]});
      send_byte({cont_marker(), code[5:0]});
    end else begin
      send_byte({4'b1110, code[15:12]});
      send_byte({cont_marker(), code[11:6]});
      send_byte({cont_marker(), code[5:0]});
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (slot_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [12:0] glyphs, input logic dflt);
    cfg_we <= 1'b1;
    cfg_index <= REG_GLYPH_COUNT;
    cfg_data <= glyphs;
    @(posedge clk);
    cfg_index <= REG_DEFAULT_FONT;
    cfg_data <= {{(GLYPH_W-1){1'b0}}, dflt};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_glyphs = glyphs;
    cfg_default = dflt;
  endtask

  task automatic test_basic_codes();
    logic [7:0] seq [$] = '{
      8'h41, 8'h00, 8'h7F, 8'hFE, 8'h41, 8'hFF,
      8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h80, 8'hFF,
      8'hC2, 8'hFF, 8'hE0, 8'hFE, 8'hFF, 8'hF0, 8'hFD, 8'hFF,
      8'hFF, 8'h41
    };
    set_config(13'd4, 1'b1);
    start_font();
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_font_done();
    drain_results();
    set_config(13'd0, 1'b0);
    start_font();
    send_byte(8'h41);
    drain_results();
    set_config(13'd1, 1'b0);
    start_font();
    send_byte(8'h55);
    send_byte(BYTE_END);
    send_byte(8'h20);
  endtask

  task automatic send_glyph_list();
    int n;
    int kind;
    n = $urandom_range(0, 3);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) send_code(16'($urandom_range(0, 127)));
      else if (kind < 6) send_code(16'($urandom_range(16'h80, 16'h7FF)));
      else if (kind < 8) begin
        // small pool so codes recur across glyphs
        if ($urandom_range(0, 1) != 0) send_code(16'h0800 + 16'($urandom_range(0, 63)));
        else send_code(16'($urandom_range(16'h800, 16'hFFFF)));
      end else if (kind == 8) send_byte(BYTE_SKIP);
      else send_byte(8'($urandom));
    end
    if ($urandom_range(0, 19) == 0) start_font();
    else send_byte(BYTE_END);
  endtask

  task automatic test_random_tables();
    logic [12:0] glyphs;
    logic dflt;
    int start;
    logic paused;
    paused = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin glyphs = 13'd4096; dflt = 1'b1; end
        1: begin glyphs = 13'd2; dflt = 1'b0; end
        3: begin glyphs = 13'd4096; dflt = 1'b0; end
        default: begin
          glyphs = 13'($urandom_range(1, 80));
          dflt = 1'($urandom);
        end
      endcase
      drain_results();
      idle_on = (phase != 3);
      set_config(glyphs, dflt);
      start_font();
      start = beats_sent;
      while (beats_sent - start < 100) begin
        send_glyph_list();
        if (phase == 2 && !paused && beats_sent - start >= 50) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  task automatic test_slot_exhaustion();
    logic [15:0] code;
    idle_on = 1'b0;
    drain_results();
    set_config(13'd4096, 1'b1);
    start_font();
    code = 16'h1000;
    while (next_free < MAX_SLOTS) begin
      while (slot_of_code[code] != '0) code++;
      send_code(code);
      send_byte(BYTE_END);
      code++;
    end
    // no slots left: fresh codes are refused, a mapped code still reports
    repeat (3) begin
      while (slot_of_code[code] != '0) code++;
      send_code(code);
      send_byte(8'h80);
      send_code(16'h0041);
      send_byte(BYTE_END);
      code++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (slot_reports_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        oldest = slot_reports_due.pop_front();
        compare_field("slot_allocated", 16'(out_data.slot_allocated),
                      16'(oldest.slot_allocated));
        compare_field("source_glyph", 16'(out_data.source_glyph),
                      16'(oldest.source_glyph));
        compare_field("slot_value", 16'(out_data.slot_value),
                      16'(oldest.slot_value));
        compare_field("map_written", 16'(out_data.map_written),
                      16'(oldest.map_written));
        compare_field("map_code", out_data.map_code, oldest.map_code);
        compare_field("alias_written", 16'(out_data.alias_written),
                      16'(oldest.alias_written));
        compare_field("alias_code", out_data.alias_code, oldest.alias_code);
        compare_field("font_done", 16'(out_data.font_done),
                      16'(oldest.font_done));
        compare_field("overflow", 16'(out_data.overflow),
                      16'(oldest.overflow));
      end
    end
  end

  // reset clears the whole map first, so the limit sits well above the clearing time
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GLYPH_COUNT;
    cfg_data <= '0;
    for (int i = 0; i < MAP_DEPTH; i++) slot_of_code[i] = '0;
    next_free = 11'd1;
    glyph_idx = '0;
    glyph_slot = '0;
    lead = '0;
    cont1 = '0;
    pending = '0;
    cfg_glyphs = 13'd256;
    cfg_default = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_codes();
    test_font_done();
    test_random_tables();
    test_slot_exhaustion();
    drain_results();
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
